// File: hdl/jsfx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jsfx_pkg;

   // Width of the clamped key length; it covers every allowed key size.
   localparam int KLEN_W = 6;

   // Number of key characters held in the two key registers.
   localparam int KEY_REG_BYTES = 16;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [1:0] CSR_KEY_LEN  = 2'd2;

   // Characters the parser reacts to.
   localparam logic [7:0] CH_COLON     = 8'h3A;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_BS        = 8'h08;

   // Control from the parser to every window cell.
   typedef struct packed {
      logic shift;
      logic clear;
   } jsfx_win_ctl_type;

endpackage

`default_nettype wire

// File: hdl/jsfx_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module jsfx_cell #(
   parameter int IDX = 0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire jsfx_pkg::jsfx_win_ctl_type  win_ctl,
   input  wire logic [jsfx_pkg::KLEN_W-1:0] klen,
   input  wire logic [jsfx_pkg::KEY_REG_BYTES*8-1:0] key_bytes,
   input  wire logic [7:0]                  din,
   output logic      [7:0]                  dout,
   output logic                             hit
);
   import jsfx_pkg::*;

   localparam logic [KLEN_W-1:0] POS = KLEN_W'(IDX);

   logic [7:0]        byte_ff;
   logic [7:0]        byte_in;
   logic [KLEN_W-1:0] key_idx;
   logic [7:0]        key_char;
   logic [7:0]        want;
   logic              care;

   // Cell zero holds the newest byte, which must be the closing quote of the
   // pattern; the cell at klen+1 holds the opening quote; cells between hold
   // the key in reverse order; cells beyond the pattern do not matter.
   always_comb begin
      key_idx  = klen - POS;
      key_char = (key_idx < KLEN_W'(KEY_REG_BYTES)) ?
                 key_bytes[key_idx[3:0]*8 +: 8] : 8'd0;
      if (POS == '0 || POS == klen + KLEN_W'(1)) begin
         want = CH_QUOTE;
         care = 1'b1;
      end else if (POS <= klen) begin
         want = key_char;
         care = 1'b1;
      end else begin
         want = 8'd0;
         care = 1'b0;
      end
      hit = !care || (din == want);
   end

   always_comb begin
      byte_in = byte_ff;
      if (win_ctl.clear) begin
         byte_in = 8'd0;
      end else if (win_ctl.shift) begin
         byte_in = din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign dout = byte_ff;

endmodule

`default_nettype wire

// File: hdl/jsfx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module jsfx_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic                       req_kind,
   input  wire logic [7:0]                 req_byte,
   input  wire logic                       win_hit,
   output jsfx_pkg::jsfx_win_ctl_type      win_ctl,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [7:0]                 rsp_out_byte,
   output logic                            rsp_byte_valid,
   output logic                            rsp_done,
   output logic                            rsp_found
);
   import jsfx_pkg::*;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_COLON,
      PH_SPACE,
      PH_VALUE,
      PH_ESCAPE,
      PH_DONE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic       started_ff, started_in;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       bv_ff, done_ff, found_ff;

   logic       accept;
   logic       emit;
   logic [7:0] emit_byte;
   logic       emit_bv, emit_done, emit_found;
   logic       is_space;
   logic [7:0] decoded;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign is_space = (req_byte == CH_SPACE) ||
                     (req_byte >= CH_TAB && req_byte <= CH_CR);

   always_comb begin
      unique case (req_byte)
         CH_LOWER_B: decoded = CH_BS;
         CH_LOWER_F: decoded = CH_FF;
         CH_LOWER_N: decoded = CH_LF;
         CH_LOWER_R: decoded = CH_CR;
         CH_LOWER_T: decoded = CH_TAB;
         default:    decoded = req_byte;
      endcase
   end

   always_comb begin
      win_ctl.shift = accept && !req_kind && (phase_ff == PH_SEARCH);
      win_ctl.clear = accept && req_kind;
   end

   always_comb begin
      phase_in   = phase_ff;
      started_in = started_ff;
      emit       = 1'b0;
      emit_byte  = 8'd0;
      emit_bv    = 1'b0;
      emit_done  = 1'b0;
      emit_found = 1'b0;
      if (req_kind) begin
         // End of body: report unless already reported, then start over.
         if (phase_ff == PH_ESCAPE) begin
            emit       = 1'b1;
            emit_byte  = CH_BACKSLASH;
            emit_bv    = 1'b1;
            emit_done  = 1'b1;
            emit_found = started_ff;
         end else if (phase_ff != PH_DONE) begin
            emit       = 1'b1;
            emit_done  = 1'b1;
            emit_found = started_ff;
         end
         phase_in   = PH_SEARCH;
         started_in = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_SEARCH: begin
               if (win_hit) phase_in = PH_COLON;
            end
            PH_COLON: begin
               if (req_byte == CH_COLON) phase_in = PH_SPACE;
            end
            PH_SPACE: begin
               if (req_byte == CH_QUOTE) begin
                  phase_in   = PH_VALUE;
                  started_in = 1'b1;
               end else if (!is_space) begin
                  phase_in  = PH_DONE;
                  emit      = 1'b1;
                  emit_done = 1'b1;
               end
            end
            PH_VALUE: begin
               if (req_byte == CH_QUOTE) begin
                  phase_in   = PH_DONE;
                  emit       = 1'b1;
                  emit_done  = 1'b1;
                  emit_found = 1'b1;
               end else if (req_byte == CH_BACKSLASH) begin
                  phase_in = PH_ESCAPE;
               end else begin
                  emit      = 1'b1;
                  emit_byte = req_byte;
                  emit_bv   = 1'b1;
               end
            end
            PH_ESCAPE: begin
               phase_in  = PH_VALUE;
               emit      = 1'b1;
               emit_byte = decoded;
               emit_bv   = 1'b1;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SEARCH;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            started_ff <= started_in;
         end
         if (accept && emit) begin
            valid_ff <= 1'b1;
            byte_ff  <= emit_byte;
            bv_ff    <= emit_bv;
            done_ff  <= emit_done;
            found_ff <= emit_found;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid     = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_done       = done_ff;
   assign rsp_found      = found_ff;

endmodule

`default_nettype wire

// File: hdl/json_string_field_extractor_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Direction  Handshake              Payload
// req_       in         tvalid / tready        tdata byte_value, tuser kind
// rsp_       out        tvalid / tready        tdata out_byte, tuser byte_valid and found,
//                                              tlast done_res
// csr_       in         we (no wait)           index, 64-bit write data
//
// The key window and the parser state update in the same cycle the item is
// accepted, and a result appears in the output register on the next cycle.
// A new item is accepted whenever the output register is empty or being
// drained, so a held result stalls the input only when rsp_tready is low.
// The synchronous reset empties the window, the output register and the
// parser state and clears the key registers; no clearing pass is needed.

module json_string_field_extractor_unit #(
   parameter int MAX_KEY_BYTES = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tuser,   // [0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic      [1:0]  rsp_tuser,   // [0] byte_valid, [1] found
   output logic             rsp_tlast,   // done_res
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);
   import jsfx_pkg::*;

   // The window keeps the key plus its two quotes.
   localparam int WIN_DEPTH = MAX_KEY_BYTES + 2;

   logic [63:0]       key_low_ff;
   logic [63:0]       key_high_ff;
   logic [4:0]        key_len_ff;
   logic [KLEN_W-1:0] klen;

   jsfx_win_ctl_type  win_ctl;
   logic [7:0]        win_data [WIN_DEPTH+1];
   logic [WIN_DEPTH-1:0] cell_hit;
   logic              win_hit;

   // The user must write the key registers only while the block is idle; the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= 64'd0;
         key_high_ff <= 64'd0;
         key_len_ff  <= 5'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LEN:  key_len_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // A key length beyond MAX_KEY_BYTES is treated as MAX_KEY_BYTES.
   assign klen = ({1'b0, key_len_ff} > KLEN_W'(MAX_KEY_BYTES)) ?
                 KLEN_W'(MAX_KEY_BYTES) : {1'b0, key_len_ff};

   // The newest byte enters cell zero and older bytes move one cell further
   // on every shift. Each cell compares the byte it is about to take with its
   // pattern character, so the match is known in the cycle the byte arrives.
   // A zero byte never equals the opening quote, so a partly filled window
   // cannot match.
   assign win_data[0] = req_tdata;

   for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
      jsfx_cell #(
         .IDX (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .win_ctl   (win_ctl),
         .klen      (klen),
         .key_bytes ({key_high_ff, key_low_ff}),
         .din       (win_data[i]),
         .dout      (win_data[i+1]),
         .hit       (cell_hit[i])
      );
   end

   assign win_hit = &cell_hit;

   // The parser follows the phases of the value and owns the output register.
   jsfx_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_kind       (req_tuser),
      .req_byte       (req_tdata),
      .win_hit        (win_hit),
      .win_ctl        (win_ctl),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_out_byte   (rsp_tdata),
      .rsp_byte_valid (rsp_tuser[0]),
      .rsp_done       (rsp_tlast),
      .rsp_found      (rsp_tuser[1])
   );

endmodule

`default_nettype wire

// File: bench/tb_json_string_field_extractor_unit.sv
`timescale 1ns / 1ps

module tb_json_string_field_extractor_unit;
   import jsfx_pkg::*;

   // The block is built with its default key capacity, so the search window
   // holds the key plus the two quotes around it.
   localparam int KEY_MAX = 16;
   localparam int WIN_DEPTH = KEY_MAX + 2;

   // Cycles without any accepted item on either channel before the run is
   // declared hung.
   localparam int IDLE_LIMIT = 5000;

   // Items per random phase; eight phases give roughly 950 items in total.
   localparam int PHASE_ITEMS = 105;

   // Parser position within one body.
   typedef enum logic [2:0] {
      PARSE_KEY,
      PARSE_COLON,
      PARSE_SPACE,
      PARSE_VALUE,
      PARSE_ESCAPE,
      PARSE_DONE
   } parse_phase_type;

   // One result item as it should appear on the rsp_ channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      logic       found;
   } field_result_type;

   class field_extract_tracker;
      logic [63:0]      key_low;
      logic [63:0]      key_high;
      logic [4:0]       key_len;
      logic [7:0]       window [WIN_DEPTH];
      int unsigned      bytes_seen;
      parse_phase_type  phase;
      bit               value_started;
      field_result_type extracted_q [$];
      int unsigned      errors;
      int unsigned      value_bytes;
      int unsigned      found_count;
      int unsigned      missing_count;

      function new();
         key_low = '0;
         key_high = '0;
         key_len = '0;
         errors = 0;
         value_bytes = 0;
         found_count = 0;
         missing_count = 0;
         clear_body();
      endfunction

      function void clear_body();
         foreach (window[i]) window[i] = 8'h00;
         bytes_seen = 0;
         phase = PARSE_KEY;
         value_started = 1'b0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [63:0] value);
         case (idx)
            CSR_KEY_LOW:  key_low = value;
            CSR_KEY_HIGH: key_high = value;
            CSR_KEY_LEN:  key_len = value[4:0];
            default: ;
         endcase
      endfunction

      function logic [7:0] key_char(int unsigned j);
         if (j < 8) return key_low[8*j +: 8];
         if (j < 16) return key_high[8*(j-8) +: 8];
         return 8'h00;
      endfunction

      // Overlong key lengths are clamped to the key capacity.
      function int unsigned key_span();
         return (key_len > KEY_MAX) ? KEY_MAX : key_len;
      endfunction

      // window[0] is the newest byte and lines up with the closing quote.
      function bit quoted_key_seen();
         int unsigned plen;
         int unsigned pos;
         logic [7:0]  want;
         plen = key_span() + 2;
         if (bytes_seen < plen) return 1'b0;
         for (int unsigned i = 0; i < plen; i++) begin
            pos = plen - 1 - i;
            want = (pos == 0 || pos == plen - 1) ? CH_QUOTE : key_char(pos - 1);
            if (window[i] != want) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void add_result(logic [7:0] b, bit bv, bit done, bit fnd);
         field_result_type r;
         r.out_byte = bv ? b : 8'h00;
         r.byte_valid = bv;
         r.done_res = done;
         r.found = done && fnd;
         extracted_q.push_back(r);
      endfunction

      function logic [7:0] unescape(logic [7:0] c);
         case (c)
            CH_LOWER_B: return CH_BS;
            CH_LOWER_F: return CH_FF;
            CH_LOWER_N: return CH_LF;
            CH_LOWER_R: return CH_CR;
            CH_LOWER_T: return CH_TAB;
            default:    return c;
         endcase
      endfunction

      // Advances the parser by one accepted item and queues its result, if any.
      function void parse_item(bit kind, logic [7:0] c);
         if (kind) begin
            if (phase == PARSE_ESCAPE) add_result(CH_BACKSLASH, 1'b1, 1'b1, value_started);
            else if (phase != PARSE_DONE) add_result(8'h00, 1'b0, 1'b1, value_started);
            clear_body();
            return;
         end
         case (phase)
            PARSE_KEY: begin
               for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
               window[0] = c;
               if (bytes_seen < WIN_DEPTH) bytes_seen++;
               if (quoted_key_seen()) phase = PARSE_COLON;
            end
            PARSE_COLON: begin
               if (c == CH_COLON) phase = PARSE_SPACE;
            end
            PARSE_SPACE: begin
               if (c == CH_QUOTE) begin
                  phase = PARSE_VALUE;
                  value_started = 1'b1;
               end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                  phase = PARSE_DONE;
                  add_result(8'h00, 1'b0, 1'b1, 1'b0);
               end
            end
            PARSE_VALUE: begin
               if (c == CH_QUOTE) begin
                  phase = PARSE_DONE;
                  add_result(8'h00, 1'b0, 1'b1, 1'b1);
               end else if (c == CH_BACKSLASH) begin
                  phase = PARSE_ESCAPE;
               end else begin
                  add_result(c, 1'b1, 1'b0, 1'b0);
               end
            end
            PARSE_ESCAPE: begin
               phase = PARSE_VALUE;
               add_result(unescape(c), 1'b1, 1'b0, 1'b0);
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $realtime, msg);
      endtask

      task check_result(logic [7:0] data, logic [1:0] user, logic last);
         field_result_type want;
         if (extracted_q.size() == 0) begin
            report($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                             data, user, last));
            return;
         end
         want = extracted_q.pop_front();
         if (data !== want.out_byte)
            report($sformatf("out_byte %h, wanted %h", data, want.out_byte));
         if (user[0] !== want.byte_valid)
            report($sformatf("byte_valid %b, wanted %b", user[0], want.byte_valid));
         if (last !== want.done_res)
            report($sformatf("done_res %b, wanted %b", last, want.done_res));
         if (user[1] !== want.found)
            report($sformatf("found %b, wanted %b", user[1], want.found));
         if (want.byte_valid) value_bytes++;
         if (want.done_res) begin
            if (want.found) found_count++;
            else missing_count++;
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [7:0]  rsp_tdata;
   wire  [1:0]  rsp_tuser;
   wire         rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_KEY_LOW;
   logic [63:0] csr_wdata = '0;

   field_extract_tracker tracker;
   logic [7:0]  body_q [$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent = 0;
   int unsigned bodies_sent = 0;
   int unsigned quiet_cycles = 0;

   json_string_field_extractor_unit #(
      .MAX_KEY_BYTES(KEY_MAX)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] byte_value
      .req_tuser  (req_tuser),   // [0] kind
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [7:0] out_byte
      .rsp_tuser  (rsp_tuser),   // [0] byte_valid, [1] found
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // The receiver decides afresh every cycle whether it can take a result.
   // With a zero stall rate it is always ready.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Both channels are sampled at the same edge. A result always belongs to
   // an item accepted at an earlier edge, so checking before predicting keeps
   // the expected results in order. The same block runs the hang watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready)
            tracker.parse_item(req_tuser, req_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results still due",
                     IDLE_LIMIT, tracker.extracted_q.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offers one item and returns at the edge where it was taken. Before the
   // offer the sender may sit idle for a random number of cycles. The valid
   // stays high on return so back-to-back items need no gap.
   task automatic send_item(bit kind, logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Sends the bytes in body_q followed by the end-of-body item, whose data
   // byte is random because the block ignores it.
   task automatic send_body();
      foreach (body_q[i]) send_item(1'b0, body_q[i]);
      send_item(1'b1, 8'($urandom));
      bodies_sent++;
   endtask

   // Drops valid and waits for every outstanding result. One edge passes
   // first so the last accepted item has surely been predicted. The clock
   // then runs on before the key registers can be touched.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.extracted_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Writes all three key registers on consecutive edges.
   task automatic write_key(logic [63:0] low, logic [63:0] high, logic [4:0] len);
      logic [1:0]  idx [3];
      logic [63:0] val [3];
      idx = '{CSR_KEY_LOW, CSR_KEY_HIGH, CSR_KEY_LEN};
      val = '{low, high, {59'd0, len}};
      for (int i = 0; i < 3; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         tracker.write_reg(idx[i], val[i]);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] space_char();
      case ($urandom_range(5))
         0:       return CH_SPACE;
         1:       return CH_TAB;
         2:       return CH_LF;
         3:       return 8'h0B;
         4:       return CH_FF;
         default: return CH_CR;
      endcase
   endfunction

   // Builds one body. Most bodies are well formed around the current key with
   // random content; some have a corrupted key, a missing colon, no opening
   // quote or an unterminated value, and a few are plain noise.
   task automatic build_body();
      int unsigned shape;
      int unsigned klen;
      int unsigned ending;
      logic [7:0]  b;
      body_q.delete();
      shape = $urandom_range(99);
      klen = tracker.key_span();
      if (shape < 10) begin
         repeat ($urandom_range(1, 24)) begin
            b = ($urandom_range(3) == 0) ? CH_QUOTE : 8'($urandom);
            body_q.push_back(b);
         end
         return;
      end
      repeat ($urandom_range(0, 5)) body_q.push_back(8'($urandom));
      body_q.push_back(CH_QUOTE);
      for (int unsigned j = 0; j < klen; j++) body_q.push_back(tracker.key_char(j));
      body_q.push_back(CH_QUOTE);
      // A broken key: one byte of the quoted pattern is replaced.
      if (shape < 18)
         body_q[body_q.size() - 1 - $urandom_range(klen + 1)] = 8'($urandom);
      repeat ($urandom_range(0, 2)) begin
         b = 8'($urandom);
         body_q.push_back((b == CH_COLON) ? 8'h2C : b);
      end
      if (shape < 23) return;
      body_q.push_back(CH_COLON);
      repeat ($urandom_range(0, 3)) body_q.push_back(space_char());
      if ($urandom_range(11) == 0) begin
         body_q.push_back(8'($urandom));
         return;
      end
      body_q.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 10)) begin
         if ($urandom_range(3) == 0) begin
            body_q.push_back(CH_BACKSLASH);
            case ($urandom_range(6))
               0:       b = CH_LOWER_B;
               1:       b = CH_LOWER_F;
               2:       b = CH_LOWER_N;
               3:       b = CH_LOWER_R;
               4:       b = CH_LOWER_T;
               default: b = 8'($urandom);
            endcase
            body_q.push_back(b);
         end else begin
            b = 8'($urandom);
            body_q.push_back((b == CH_QUOTE) ? 8'h27 : b);
         end
      end
      ending = $urandom_range(9);
      if (ending == 0) begin
         body_q.push_back(CH_BACKSLASH);
      end else if (ending > 1) begin
         body_q.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 3)) body_q.push_back(8'($urandom));
      end
   endtask

   initial begin
      logic [63:0] low;
      logic [63:0] high;
      logic [4:0]  len;
      int unsigned target;

      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed bodies run with the reset key, which is empty, so the search
      // pattern is two adjacent quotes. The first body carries the lowest and
      // highest byte values, an escaped newline, an escaped quote passing as
      // itself, the closing quote and a byte after done that must be ignored.
      body_q = '{8'h00, CH_QUOTE, CH_QUOTE, CH_COLON, CH_SPACE, CH_QUOTE, 8'hFF,
                 CH_BACKSLASH, CH_LOWER_N, CH_BACKSLASH, CH_QUOTE, CH_QUOTE, 8'h78};
      send_body();
      // A value that does not open with a quote ends the search at once.
      body_q = '{CH_QUOTE, CH_QUOTE, CH_COLON, 8'h78};
      send_body();
      // The body ends right after a backslash inside the value.
      body_q = '{CH_QUOTE, CH_QUOTE, CH_COLON, CH_QUOTE, CH_BACKSLASH};
      send_body();

      // Random phases. Each one loads a new key and cycles through the flow
      // control modes: free running, sender gaps, receiver stalls, and light
      // pressure on both sides.
      for (int p = 0; p < 8; p++) begin
         drain();
         case (p % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
         endcase
         low = {$urandom, $urandom};
         high = {$urandom, $urandom};
         case (p)
            0: begin
               low = '1;
               len = 5'd16;
            end
            1: len = 5'd0;
            // Longer than the window; the block clamps it to the full key.
            2: len = 5'd31;
            3: begin
               high = '0;
               len = 5'd1;
            end
            default: len = 5'($urandom_range(2, 15));
         endcase
         write_key(low, high, len);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            build_body();
            send_body();
         end
      end
      drain();

      if (tracker.extracted_q.size() != 0)
         tracker.report($sformatf("%0d results never arrived",
                                  tracker.extracted_q.size()));

      $display("Sent %0d items in %0d bodies over 8 keys, lengths from empty to overlong.",
               items_sent, bodies_sent);
      $display("Checked %0d value bytes; %0d bodies found a value, %0d did not.",
               tracker.value_bytes, tracker.found_count, tracker.missing_count);
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/jsfx_pkg.sv
hdl/jsfx_cell.sv
hdl/jsfx_ctrl.sv
hdl/json_string_field_extractor_unit.sv
bench/tb_json_string_field_extractor_unit.sv
